// File: rtl/core/ovm_pkg.sv
// Shared constants for the oversampled voltmeter: field widths, scaling
// and decimal split constants, ASCII codes. No dependencies.
`default_nettype none

package ovm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int SCALE_W  = 20;
    localparam int BYTE_W   = 8;
    localparam int GROUP_W  = 4;   // sixteen samples per reading

    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd402817;

    // Centivolt reading, saturated
    localparam int          CV_W   = 14;
    localparam logic [13:0] CV_MAX = 14'd9999;

    // Reciprocals: x/100 = (x*5243)>>19 for x<10000, y/10 = (y*205)>>11 for y<100
    localparam int          RECIP100_W  = 13;
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;
    localparam int          RECIP10_W   = 8;
    localparam logic [7:0]  RECIP10     = 8'd205;
    localparam int          RECIP10_SH  = 11;
    localparam int          PAIR_W      = 7;   // 0..99
    localparam int          DIGIT_W     = 4;

    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] ASCII_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_LF    = 8'h0A;

endpackage

`default_nettype wire

// File: rtl/core/ovm_front.sv
// Front end: accumulates sixteen samples and pushes the decimated reading.
// Depends on ovm_pkg.
`default_nettype none

module ovm_front
    import ovm_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       q_push,
    output logic [ADC_BITS+1:0]        q_data
);

    localparam int SUM_W = ADC_BITS + 4;
    localparam int EXT_W = SAMPLE_W + ADC_BITS;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [GROUP_W-1:0] cnt_reg, cnt_next;
    logic [EXT_W-1:0]   sample_ext;
    logic [SUM_W-1:0]   sum_add;

    // bits above ADC_BITS are dropped, missing ones read as zero
    assign sample_ext = EXT_W'(sample);
    assign sum_add    = sum_reg + SUM_W'(sample_ext[ADC_BITS-1:0]);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        q_push   = 1'b0;
        q_data   = sum_add[SUM_W-1:2];
        if (accept)
        begin
            cnt_next = cnt_reg + GROUP_W'(1);
            if (cnt_reg == {GROUP_W{1'b1}})
            begin
                q_push   = 1'b1;
                sum_next = '0;
            end
            else
            begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ovm_queue.sv
// Two-entry queue of readings between front and back end.
// No dependencies.
`default_nettype none

module ovm_queue
#(
    parameter int WIDTH = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ovm_back.sv
// Back end: scales a reading to centivolts, splits it into decimal digits
// and sends the seven ASCII bytes through an output register. Depends on ovm_pkg.
`default_nettype none

module ovm_back
    import ovm_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [SCALE_W-1:0]   scale,
    input  wire logic [ADC_BITS+1:0]  q_data,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [BYTE_W-1:0]         text_byte,
    output logic                      last_byte
);

    localparam int VAL_W  = ADC_BITS + 2;
    localparam int PROD_W = VAL_W + SCALE_W;
    localparam int RND_W  = PROD_W + 1 - SCALE_W;
    localparam int CMP_W  = (RND_W > CV_W) ? RND_W : CV_W;
    localparam int DIV_W  = CV_W + RECIP100_W;
    localparam int D10_W  = PAIR_W + RECIP10_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_REM   = 6'b001000,
        ST_DIG   = 6'b010000,
        ST_EMIT  = 6'b100000
    } back_state_t;

    typedef enum logic [2:0] {
        B_TENS  = 3'd0,
        B_UNITS = 3'd1,
        B_COMMA = 3'd2,
        B_TENTH = 3'd3,
        B_HUND  = 3'd4,
        B_CR    = 3'd5,
        B_LF    = 3'd6
    } byte_sel_t;

    back_state_t         state_reg, state_next;
    byte_sel_t           sel_reg, sel_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CV_W-1:0]     cv_reg, cv_next;
    logic [PAIR_W-1:0]   hi_reg, hi_next;
    logic [PAIR_W-1:0]   lo_reg, lo_next;
    logic [DIGIT_W-1:0]  dig_reg [4];
    logic [DIGIT_W-1:0]  dig_next [4];
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic                valid_reg, valid_next;

    logic [RND_W-1:0]    rounded;
    logic [CMP_W-1:0]    rnd_ext;
    logic [DIV_W-1:0]    div_prod;
    logic [CV_W-1:0]     hi_times100;
    logic [D10_W-1:0]    hi_prod, lo_prod;
    logic [DIGIT_W-1:0]  hi_tens, lo_tens;
    logic                out_free;
    logic [BYTE_W-1:0]   sel_byte;

    assign empty     = !valid_reg;
    assign text_byte = byte_reg;
    assign last_byte = last_reg;
    assign out_free  = !valid_reg || pop;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    // round half up, then drop the fraction
    assign rounded = RND_W'(({1'b0, prod_reg} + (PROD_W + 1)'(1 << (SCALE_W - 1)))
                     >> SCALE_W);
    assign rnd_ext = CMP_W'(rounded);

    assign div_prod    = DIV_W'(cv_reg) * DIV_W'(RECIP100);
    assign hi_times100 = CV_W'(hi_reg) * CV_W'(100);
    assign hi_prod     = D10_W'(hi_reg) * D10_W'(RECIP10);
    assign lo_prod     = D10_W'(lo_reg) * D10_W'(RECIP10);
    assign hi_tens     = hi_prod[RECIP10_SH +: DIGIT_W];
    assign lo_tens     = lo_prod[RECIP10_SH +: DIGIT_W];

    always_comb
    begin
        case (sel_reg)
            B_TENS:  sel_byte = ASCII_ZERO + BYTE_W'(dig_reg[3]);
            B_UNITS: sel_byte = ASCII_ZERO + BYTE_W'(dig_reg[2]);
            B_COMMA: sel_byte = ASCII_COMMA;
            B_TENTH: sel_byte = ASCII_ZERO + BYTE_W'(dig_reg[1]);
            B_HUND:  sel_byte = ASCII_ZERO + BYTE_W'(dig_reg[0]);
            B_CR:    sel_byte = ASCII_CR;
            B_LF:    sel_byte = ASCII_LF;
            default: sel_byte = ASCII_LF;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        prod_next  = prod_reg;
        cv_next    = cv_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        dig_next   = dig_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !pop;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    prod_next  = PROD_W'(q_data) * PROD_W'(scale);
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cv_next    = (rnd_ext > CMP_W'(CV_MAX)) ? CV_MAX : CV_W'(rnd_ext);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                hi_next    = div_prod[RECIP100_SH +: PAIR_W];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                lo_next    = PAIR_W'(cv_reg - hi_times100);
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                dig_next[3] = hi_tens;
                dig_next[2] = DIGIT_W'(hi_reg - PAIR_W'(hi_tens) * PAIR_W'(10));
                dig_next[1] = lo_tens;
                dig_next[0] = DIGIT_W'(lo_reg - PAIR_W'(lo_tens) * PAIR_W'(10));
                sel_next    = B_TENS;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    byte_next  = sel_byte;
                    last_next  = (sel_reg == B_LF);
                    valid_next = 1'b1;
                    if (sel_reg == B_LF)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sel_next = byte_sel_t'(sel_reg + 3'd1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        cv_reg   <= cv_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        dig_reg  <= dig_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= B_TENS;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/oversampled_voltmeter_ascii_top.sv
// Top level of the oversampled voltmeter: scale register, front end,
// reading queue and back end. Depends on ovm_pkg, ovm_front, ovm_queue, ovm_back.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------
//  samples  | sample[9:0]                   | push / full
//  text     | text_byte[7:0], last_byte     | empty / pop
//  scale    | cfg_wdata[19:0]               | cfg_we, no wait
//
// One sample is taken per cycle while full is low. Every sixteenth sample pushes a
// reading into a two-entry queue; full rises only while both entries are occupied.
// The back end works through five steps per reading (multiply, round, two divide
// steps, digits), then sends seven bytes, one per cycle while pop keeps up.
// Reset clears the accumulator, queue and output; scale returns to 402817.
`default_nettype none

module oversampled_voltmeter_ascii_top
    import ovm_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     empty,
    input  wire logic                pop,
    output logic [BYTE_W-1:0]        text_byte,
    output logic                     last_byte,
    input  wire logic                cfg_we,
    input  wire logic [SCALE_W-1:0]  cfg_wdata
);

    localparam int VAL_W = ADC_BITS + 2;

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic               accept;
    logic               f_push;
    logic [VAL_W-1:0]   f_data;
    logic [VAL_W-1:0]   q_data;
    logic               q_full, q_empty, q_pop;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign scale_next = cfg_we ? cfg_wdata : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    ovm_front #(.ADC_BITS(ADC_BITS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .q_push (f_push),
        .q_data (f_data)
    );

    ovm_queue #(.WIDTH(VAL_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_data),
        .pop   (q_pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    ovm_back #(.ADC_BITS(ADC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (scale_reg),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .text_byte (text_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for oversampled_voltmeter_ascii_top: sixteen-sample readings,
// scaled to centivolts and sent as seven ASCII bytes, checked against an in-bench model.
// Depends on ovm_pkg and the RTL of the voltmeter.
`default_nettype none

module testbench;
    import ovm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 16;
    localparam int N_PHASES  = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } text_char_t;

    // Model of the accumulator, scaler and formatter, plus the queue of bytes due
    class reading_scoreboard;
        logic [SCALE_W-1:0]  scale;
        logic [SAMPLE_W+3:0] acc;
        logic [GROUP_W-1:0]  count;
        text_char_t          expected[$];
        int                  errors;

        function new();
            scale  = SCALE_RESET;
            acc    = '0;
            count  = '0;
            errors = 0;
        endfunction

        function void set_scale(logic [SCALE_W-1:0] v);
            scale = v;
        endfunction

        function void add_char(logic [BYTE_W-1:0] ch, logic last);
            text_char_t c;
            c.ch   = ch;
            c.last = last;
            expected.push_back(c);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [SAMPLE_W+1:0] value;
            longint unsigned     prod;
            int unsigned         cv;
            acc   = acc + s;
            count = count + 1'b1;
            if (count != '0)
                return;
            value = acc[SAMPLE_W+3:2];
            acc   = '0;
            // round half up, then saturate
            prod = longint'(value) * longint'(scale) + (64'd1 << (SCALE_W - 1));
            prod = prod >> SCALE_W;
            cv   = (prod > CV_MAX) ? int'(CV_MAX) : int'(prod);
            add_char(ASCII_ZERO + BYTE_W'(cv / 1000), 1'b0);
            add_char(ASCII_ZERO + BYTE_W'((cv / 100) % 10), 1'b0);
            add_char(ASCII_COMMA, 1'b0);
            add_char(ASCII_ZERO + BYTE_W'((cv / 10) % 10), 1'b0);
            add_char(ASCII_ZERO + BYTE_W'(cv % 10), 1'b0);
            add_char(ASCII_CR, 1'b0);
            add_char(ASCII_LF, 1'b1);
        endfunction

        function void check_byte(logic [BYTE_W-1:0] ch, logic last);
            text_char_t want;
            if (expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected byte: expected none, got %h last %b",
                         $time, ch, last);
                return;
            end
            want = expected.pop_front();
            if (ch !== want.ch)
            begin
                errors++;
                $display("%0t: text_byte mismatch: expected %h, got %h",
                         $time, want.ch, ch);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_byte mismatch: expected %b, got %b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [SAMPLE_W-1:0] sample;
    logic                empty;
    logic                pop;
    logic [BYTE_W-1:0]   text_byte;
    logic                last_byte;
    logic                cfg_we;
    logic [SCALE_W-1:0]  cfg_wdata;

    reading_scoreboard sb = new();
    bit                hold_request = 1'b0;

    oversampled_voltmeter_ascii_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(int kind);
        case (kind)
            0:       return SAMPLE_W'($urandom_range(0, 1023));
            1:       return '1;
            2:       return '0;
            3:       return SAMPLE_W'($urandom_range(1000, 1023));
            default: return SAMPLE_W'($urandom_range(0, 15));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_byte(text_byte, last_byte);
    end

    // Byte sink: random pauses, steady runs, and one long hold-off on request
    initial
    begin : text_sink
        int n;
        int steady;
        steady = 0;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (steady > 0)
            begin
                steady--;
                n = 0;
            end
            else
            begin
                n = gap_len();
                if ($urandom_range(0, 19) == 0)
                    steady = 30;
            end
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit bursty);
        int n;
        n = bursty ? 0 : gap_len();
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        do @(posedge clk); while (full);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_scale(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A partial group makes no bytes, so allow the back end time to settle too
    task automatic wait_drained();
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [SCALE_W-1:0] scales [N_PHASES];
        int                 groups;
        int                 extra;
        int                 kind;
        bit                 bursty;
        push      = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: sample extremes at the reset scale
        for (int i = 0; i < 16; i++)
            push_sample(i[0] ? '1 : '0, 1'b0);
        push <= 1'b0;
        wait_drained();

        scales[0] = '1;
        scales[1] = '0;
        scales[2] = SCALE_W'(1 << (SCALE_W - 1));   // exact halves on odd readings
        scales[3] = SCALE_W'($urandom_range(1, (1 << SCALE_W) - 2));
        scales[4] = SCALE_W'($urandom_range(1, (1 << SCALE_W) - 2));
        scales[5] = SCALE_RESET;

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_scale(scales[p]);
            groups = (p == 0) ? 4 : ((p == 1) ? 1 : 2);
            bursty = (p == 0) || (p == 3);
            if (p == 0)
                hold_request = 1'b1;
            for (int g = 0; g < groups; g++)
            begin
                kind = $urandom_range(0, 5);
                for (int i = 0; i < 16; i++)
                    push_sample(pick_sample(kind), bursty);
            end
            // leftover samples straddle the next scale write
            extra = $urandom_range(0, 3);
            for (int i = 0; i < extra; i++)
                push_sample(pick_sample(0), bursty);
            push <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE) @(negedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: oversampled_voltmeter_ascii_top.f
rtl/core/ovm_pkg.sv
rtl/core/ovm_front.sv
rtl/core/ovm_queue.sv
rtl/core/ovm_back.sv
rtl/core/oversampled_voltmeter_ascii_top.sv
tb/testbench.sv
